>>> src/fdgp_pkg.sv
// Shared constants and types of the forward-difference gradient polar unit.
package fdgp_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int ANGLE_FRAC_DEFAULT = 13;

   localparam int PIX_W   = 8;
   localparam int GRAD_W  = 9;
   localparam int MAG_W   = 8;
   localparam int DIR_W   = 16;
   localparam int CFG_W   = 12;
   localparam int RSP_W   = 48;

   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);

   // Fixed-point format of the angle series.
   localparam int FIX_BITS   = 40;
   localparam int TERM_W     = 40;
   localparam int SUM_W      = 43;
   localparam int NUM_W      = 56;
   localparam int DEN_W      = 17;
   localparam int SERIES_MAX = 100;
   localparam int N_W        = 7;

   typedef enum logic [10:0] {
      ST_BOOT  = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_READ  = 11'b000_0000_0100,
      ST_SQRT  = 11'b000_0000_1000,
      ST_SQFIN = 11'b000_0001_0000,
      ST_SETUP = 11'b000_0010_0000,
      ST_MUL   = 11'b000_0100_0000,
      ST_START = 11'b000_1000_0000,
      ST_WAIT  = 11'b001_0000_0000,
      ST_DONE  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_SCALE = 2'd1,
      PH_RATIO = 2'd2
   } phase_type;

endpackage

>>> src/forward_difference_gradient_polar_unit.sv
// Top level of the forward-difference gradient polar unit.
//
// Pixels enter on the req_ stream in raster order, one 8-bit grey level each,
// with req_tuser marking the first pixel of a frame. Each pixel yields one
// result on the rsp_ stream: horizontal and vertical forward differences, the
// rounded gradient length saturated at 255, and the direction in radians
// scaled by 2^ANGLE_FRAC_BITS. The csr_ channel writes the row width; write it
// only while no pixel is in flight.
// One pixel is processed at a time. A zero gradient passes through idle, line
// buffer read, nine square root steps, rounding and output. Any other
// gradient runs the arctangent series on one bit-serial divider with a 56-bit
// dividend: this adds the first division and the octant fold (and no series
// terms for axis-aligned gradients), and each term adds two divisions. Terms
// run until a term truncates to zero, up to about 38 near the diagonal.
// After reset the unit first evaluates the same series for pi/4 before it
// takes any pixel; csr writes are taken during that time.
// A finished result waits in an output register; the next pixel is accepted
// and processed meanwhile, and only its final transfer waits on rsp_tready.
module forward_difference_gradient_polar_unit #(
   parameter int MAX_WIDTH       = fdgp_pkg::MAX_WIDTH_DEFAULT,
   parameter int ANGLE_FRAC_BITS = fdgp_pkg::ANGLE_FRAC_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: [7:0] pixel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [fdgp_pkg::PIX_W-1:0]   req_tdata,
   // req_tuser: [0] frame_start
   input  logic                         req_tuser,
   // rsp_tdata: [8:0] grad_x, [17:9] grad_y, [25:18] magnitude,
   //            [41:26] direction, [47:42] zero
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [fdgp_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fdgp_pkg::CFG_W-1:0]   csr_data
);
   import fdgp_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int SHIFT = FIX_BITS - ANGLE_FRAC_BITS;
   localparam logic [SUM_W:0] HALF = (SUM_W+1)'(1) << (SHIFT - 1);

   state_type          state_ff;
   phase_type          phase_ff;
   logic               boot_ff;
   logic [CFG_W-1:0]   width_ff;
   logic [AW-1:0]      col_ff;
   logic               first_row_ff;
   logic [PIX_W-1:0]   left_ff;

   logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   above_ff;

   logic [PIX_W-1:0]   pix_ff;
   logic               first_ff;
   logic [GRAD_W-1:0]  gx_ff;
   logic [GRAD_W-1:0]  gy_ff;
   logic [PIX_W-1:0]   ax_ff;
   logic [PIX_W-1:0]   ay_ff;
   logic [DEN_W-1:0]   s_ff;
   logic [8:0]         root_ff;
   logic [3:0]         bit_ff;
   logic [MAG_W-1:0]   mag_ff;

   logic [PIX_W-1:0]   a_ff;
   logic [PIX_W-1:0]   b_ff;
   logic [DEN_W-1:0]   r2_ff;
   logic [15:0]        bb_ff;
   logic [NUM_W-1:0]   prod_ff;
   logic [TERM_W-1:0]  t_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [N_W-1:0]     n_ff;
   logic [SUM_W-1:0]   quarter_ff;
   logic [SUM_W-1:0]   ang_ff;

   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic               accept;
   logic [CW-1:0]      w_eff;
   logic               wrap;
   logic [AW-1:0]      col_eff;
   logic               first_eff;
   logic [CW-1:0]      col_nxt;
   logic [GRAD_W-1:0]  gx_new;
   logic [GRAD_W-1:0]  gy_new;
   logic [GRAD_W-1:0]  gx_abs;
   logic [GRAD_W-1:0]  gy_abs;
   logic [8:0]         root_try;
   logic [17:0]        root_sq;
   logic [17:0]        root_rem;
   logic [9:0]         root_rnd;
   logic               swap;
   logic [SUM_W-1:0]   ang_swap;
   logic [SUM_W-1:0]   ang_full;
   logic [SUM_W:0]     ang_rnd;
   logic [DIR_W-1:0]   dir_mag;
   logic [DIR_W-1:0]   dir_val;
   logic               out_free;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;
   logic [TERM_W-1:0]  quo_t;
   logic [N_W-1:0]     n_inc;
   logic [7:0]         two_n;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Clamp the configured width and place the pixel in its row.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      wrap      = CW'(col_ff) >= w_eff;
      col_eff   = (req_tuser || wrap) ? '0 : col_ff;
      first_eff = req_tuser ? 1'b1 : (wrap ? 1'b0 : first_row_ff);
      col_nxt   = CW'(col_eff) + CW'(1);
      gx_new    = (col_eff == '0) ? GRAD_W'(1)
                                  : {1'b0, req_tdata} - {1'b0, left_ff};
   end

   // Vertical difference, absolute values, square root trial.
   always_comb begin
      gy_new   = first_ff ? GRAD_W'(1) : {1'b0, pix_ff} - {1'b0, above_ff};
      gx_abs   = gx_ff[GRAD_W-1] ? -gx_ff : gx_ff;
      gy_abs   = gy_new[GRAD_W-1] ? -gy_new : gy_new;
      root_try = root_ff | (9'd1 << bit_ff);
      root_sq  = 18'(root_ff) * 18'(root_ff);
      root_rem = 18'(s_ff) - root_sq;
      root_rnd = 10'(root_ff) + ((root_rem > 18'(root_ff)) ? 10'd1 : 10'd0);
      swap     = ay_ff > ax_ff;
   end

   // Unfold the octant, round and sign the angle.
   always_comb begin
      ang_swap = sum_ff;
      if (swap) begin
         ang_swap = ((quarter_ff << 1) > sum_ff) ? (quarter_ff << 1) - sum_ff : '0;
      end
      ang_full = ang_swap;
      if (gx_ff[GRAD_W-1]) begin
         ang_full = ((quarter_ff << 2) > ang_swap) ? (quarter_ff << 2) - ang_swap : '0;
      end
      ang_rnd = ({1'b0, ang_ff} + HALF) >> SHIFT;
      dir_mag = ang_rnd[DIR_W-1:0];
      dir_val = gy_ff[GRAD_W-1] ? -dir_mag : dir_mag;
   end

   // Divider operands.
   always_comb begin
      two_n     = {n_ff, 1'b0};
      n_inc     = n_ff + N_W'(1);
      quo_t     = div_quo[TERM_W-1:0];
      div_start = (state_ff == ST_START);
      div_num   = prod_ff;
      div_den   = (phase_ff == PH_RATIO) ? DEN_W'(two_n) + DEN_W'(1) : r2_ff;
   end

   fdgp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Line buffer: read the pixel above and write the current one back.
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff          <= line_mem[col_eff];
         line_mem[col_eff] <= req_tdata;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   // Position counters and left neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         left_ff      <= '0;
      end else if (accept) begin
         left_ff <= req_tdata;
         if (col_nxt >= w_eff) begin
            col_ff       <= '0;
            first_row_ff <= 1'b0;
         end else begin
            col_ff       <= col_nxt[AW-1:0];
            first_row_ff <= first_eff;
         end
      end
   end

   // Sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         boot_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_BOOT:  state_ff <= ST_SETUP;
            ST_IDLE:  if (accept) state_ff <= ST_READ;
            ST_READ:  state_ff <= ST_SQRT;
            ST_SQRT:  if (bit_ff == 4'd0) state_ff <= ST_SQFIN;
            ST_SQFIN: begin
               if (ax_ff == '0 && ay_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: state_ff <= ST_START;
            ST_MUL:   state_ff <= ST_START;
            ST_START: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (div_done) begin
                  case (phase_ff)
                     PH_FIRST: state_ff <= (quo_t == '0) ? ST_DONE : ST_MUL;
                     PH_SCALE: state_ff <= ST_MUL;
                     default: begin
                        if (32'(n_inc) < SERIES_MAX && quo_t != '0) begin
                           state_ff <= ST_MUL;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                  endcase
               end
            end
            ST_DONE: begin
               if (boot_ff) begin
                  boot_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT:   if (out_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_BOOT;
         endcase
      end
   end

   // Per-pixel datapath: differences and square root.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_tdata;
         first_ff <= first_eff;
         gx_ff    <= gx_new;
      end
      if (state_ff == ST_READ) begin
         gy_ff   <= gy_new;
         ax_ff   <= gx_abs[PIX_W-1:0];
         ay_ff   <= gy_abs[PIX_W-1:0];
         s_ff    <= DEN_W'(gx_abs) * DEN_W'(gx_abs) + DEN_W'(gy_abs) * DEN_W'(gy_abs);
         root_ff <= '0;
         bit_ff  <= 4'd8;
      end
      if (state_ff == ST_SQRT) begin
         if (18'(root_try) * 18'(root_try) <= 18'(s_ff)) begin
            root_ff <= root_try;
         end
         bit_ff <= bit_ff - 4'd1;
      end
      if (state_ff == ST_SQFIN) begin
         mag_ff <= (root_rnd > 10'd255) ? MAG_W'(255) : root_rnd[MAG_W-1:0];
         a_ff   <= swap ? ay_ff : ax_ff;
         b_ff   <= swap ? ax_ff : ay_ff;
         ang_ff <= '0;
      end
      if (state_ff == ST_BOOT) begin
         a_ff <= PIX_W'(1);
         b_ff <= PIX_W'(1);
      end
      if (state_ff == ST_DONE) begin
         ang_ff <= ang_full;
         if (boot_ff) begin
            quarter_ff <= sum_ff;
         end
      end
   end

   // Arctangent series datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_SETUP: begin
            r2_ff    <= DEN_W'(16'(a_ff) * 16'(a_ff)) + DEN_W'(16'(b_ff) * 16'(b_ff));
            bb_ff    <= 16'(b_ff) * 16'(b_ff);
            prod_ff  <= {16'(a_ff) * 16'(b_ff), {FIX_BITS{1'b0}}};
            phase_ff <= PH_FIRST;
         end
         ST_MUL: begin
            if (phase_ff == PH_SCALE) begin
               prod_ff <= NUM_W'(t_ff) * NUM_W'(bb_ff);
            end else begin
               prod_ff <= NUM_W'(t_ff) * NUM_W'(two_n);
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               t_ff <= quo_t;
               case (phase_ff)
                  PH_FIRST: begin
                     sum_ff   <= SUM_W'(quo_t);
                     n_ff     <= N_W'(1);
                     phase_ff <= PH_SCALE;
                  end
                  PH_SCALE: phase_ff <= PH_RATIO;
                  default: begin
                     sum_ff   <= sum_ff + SUM_W'(quo_t);
                     n_ff     <= n_inc;
                     phase_ff <= PH_SCALE;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load when free, drop valid on transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {6'b0, dir_val, mag_ff, gy_ff, gx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/fdgp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module fdgp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fdgp_pkg::NUM_W-1:0]  num,
   input  logic [fdgp_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [fdgp_pkg::NUM_W-1:0]  quo
);
   import fdgp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] sh_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W:0]   diff;

   // Trial subtraction of the next remainder.
   always_comb begin
      trial = {rem_ff, sh_ff[NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
   end

   // Control: count quotient bits, pulse done after the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: shift dividend out, quotient in.
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         sh_ff  <= {sh_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

>>> src/fdgp_checker.sv
// Port-level checks of the gradient polar unit, bound to the top level.
module fdgp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [fdgp_pkg::RSP_W-1:0] rsp_tdata
);
   import fdgp_pkg::*;

   // No result comes out of reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // One pixel at a time: busy after each input transfer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a pixel is in work");

   // Differences stay within -255..255 and padding stays zero.
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:0] != 9'h100 && rsp_tdata[17:9] != 9'h100
                     && rsp_tdata[47:42] == 6'b0)
      else $error("result field out of range");

endmodule

bind forward_difference_gradient_polar_unit fdgp_checker u_fdgp_checker (.*);
